FILE: design/awd_pkg.sv
// Shared types, constants and helpers for the adaptive hang watchdog.
// No dependencies; every other file of the block but awd_ram imports this package.
`default_nettype none

package awd_pkg;

   localparam int CHANNELS   = 8;
   localparam int WINDOW_MAX = 256;

   localparam int TIME_W   = 32;
   localparam int CH_W     = 3;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PTR_W    = $clog2(WINDOW_MAX);
   localparam int CNT_W    = $clog2(WINDOW_MAX + 1);
   localparam int WIN_W    = 9;
   localparam int THR_W    = 12;
   localparam int PROD_W   = THR_W + TIME_W;
   localparam int ADDR_W   = CH_IDX_W + PTR_W;
   localparam int HIST_DEPTH = 1 << ADDR_W;

   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] ST_STOPPED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RUNNING = 2'd1;
   localparam logic [STATUS_W-1:0] ST_HANGING = 2'd2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd1;

   typedef struct packed {
      logic             start;
      logic [PTR_W-1:0] head;
      logic [CNT_W-1:0] count;
   } scan_cmd_type;

   typedef struct packed {
      logic              done;
      logic [TIME_W-1:0] gap;
   } scan_rsp_type;

   // Ring pointer wrap: sum is always below twice the ring size.
   function automatic logic [PTR_W-1:0] ptr_wrap(input logic [CNT_W:0] sum);
      logic [CNT_W:0] res;
      if (sum >= (CNT_W + 1)'(WINDOW_MAX)) begin
         res = sum - (CNT_W + 1)'(WINDOW_MAX);
      end else begin
         res = sum;
      end
      return res[PTR_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: design/awd_if.sv
// Handshake channel interfaces for the adaptive hang watchdog.
// Depends on awd_pkg for field widths.
`default_nettype none

interface awd_req_if import awd_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CH_W-1:0]   channel;
   logic              attached;
   logic              started;
   logic [TIME_W-1:0] done_time;
   logic [TIME_W-1:0] now_time;

   modport source (output valid, channel, attached, started, done_time, now_time,
                   input ready);
   modport sink   (input valid, channel, attached, started, done_time, now_time,
                   output ready);
endinterface

interface awd_rsp_if import awd_pkg::*;;
   logic                valid;
   logic                ready;
   logic [CH_W-1:0]     report_channel;
   logic [STATUS_W-1:0] status;

   modport source (output valid, report_channel, status, input ready);
   modport sink   (input valid, report_channel, status, output ready);
endinterface

interface awd_csr_if import awd_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/awd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
`default_nettype none

module awd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: design/awd_gap_scan.sv
// Sequencer that walks one channel's history ring, one entry per cycle, and
// keeps the largest positive gap with a single subtract/compare unit. Uses awd_pkg.
`default_nettype none

module awd_gap_scan import awd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire scan_cmd_type      cmd,
   output scan_rsp_type           rsp,
   output logic                   rd_en,
   output logic [PTR_W-1:0]       rd_ptr,
   input  wire logic [TIME_W-1:0] rd_data
);

   logic              busy_ff, busy_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              first_ff, first_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic [TIME_W-1:0] prev_ff, prev_in;
   logic [TIME_W-1:0] gap_ff, gap_in;
   logic [TIME_W-1:0] diff;
   logic              wider;
   logic              finish;

   assign rd_en  = busy_ff && (left_ff != '0);
   assign rd_ptr = ptr_ff;
   assign diff   = rd_data - prev_ff;
   assign wider  = !first_ff && (rd_data > prev_ff) && (diff > gap_ff);
   assign finish = busy_ff && (left_ff == '0) && !rd_vld_ff;

   assign rsp.done = finish;
   assign rsp.gap  = gap_ff;

   always_comb begin
      busy_in   = busy_ff;
      rd_vld_in = rd_en;
      first_in  = first_ff;
      ptr_in    = ptr_ff;
      left_in   = left_ff;
      prev_in   = prev_ff;
      gap_in    = gap_ff;
      priority if (cmd.start) begin
         busy_in   = 1'b1;
         rd_vld_in = 1'b0;
         first_in  = 1'b1;
         ptr_in    = cmd.head;
         left_in   = cmd.count;
         gap_in    = '0;
      end else if (busy_ff) begin
         if (rd_en) begin
            ptr_in  = ptr_wrap((CNT_W + 1)'(ptr_ff) + (CNT_W + 1)'(1));
            left_in = left_ff - CNT_W'(1);
         end
         // compare the returning entry against the one before it
         if (rd_vld_ff) begin
            prev_in  = rd_data;
            first_in = 1'b0;
            if (wider) begin
               gap_in = diff;
            end
         end
         if (finish) begin
            busy_in = 1'b0;
         end
      end else begin
         rd_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         rd_vld_ff <= rd_vld_in;
      end
      first_ff <= first_in;
      ptr_ff   <= ptr_in;
      left_ff  <= left_in;
      prev_ff  <= prev_in;
      gap_ff   <= gap_in;
   end

endmodule

`default_nettype wire

FILE: design/adaptive_hang_watchdog_unit.sv
// Top level of the adaptive hang watchdog: per-channel state, poll sequencer,
// history RAM and timeout compare. Uses awd_pkg, awd_if, awd_ram, awd_gap_scan.
`default_nettype none

// One poll in, one report out, one poll in flight at a time. A stopped poll or
// one with a new completion time goes from S_LOOK straight to S_OUT. A poll
// with an unchanged completion time scans the channel's history through the
// single read port of the history RAM, one entry per cycle, and then passes
// S_MUL and S_CMP before S_OUT; the scan covers the valid entries, at most 256.
// The report sits in an output register, so the next poll is accepted while a
// report still waits for the sink. Configuration writes are always taken;
// history needs no clearing pass.
module adaptive_hang_watchdog_unit import awd_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   awd_req_if.sink    req_if,
   awd_rsp_if.source  rsp_if,
   awd_csr_if.sink    csr_if
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOOK = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_CMP  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;

   // configuration
   logic [WIN_W-1:0] window_ff;
   logic [THR_W-1:0] thr_ff;

   // latched poll
   logic [CH_W-1:0]   ch_ff;
   logic              active_ff;
   logic [TIME_W-1:0] done_ff;
   logic [TIME_W-1:0] now_ff;

   // per-channel state
   logic [TIME_W-1:0] last_seen_ff [CHANNELS];
   logic [TIME_W-1:0] change_ff    [CHANNELS];
   logic [PTR_W-1:0]  head_ff      [CHANNELS];
   logic [CNT_W-1:0]  count_ff     [CHANNELS];

   logic [CH_IDX_W-1:0] idx;
   logic [TIME_W-1:0]   cur_last;
   logic [TIME_W-1:0]   cur_change;
   logic [PTR_W-1:0]    cur_head;
   logic [CNT_W-1:0]    cur_count;
   logic [CNT_W-1:0]    eff_win;
   logic                changed;
   logic                push_en;
   logic [PTR_W-1:0]    push_ptr;
   logic [PTR_W-1:0]    head_in;
   logic [CNT_W-1:0]    count_in;

   logic [TIME_W-1:0]   elapsed_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                gap_zero_ff;
   logic [PROD_W-1:0]   lhs;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]     rsp_ch_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic                req_beat;
   logic                load_out;

   scan_cmd_type        scan_cmd;
   scan_rsp_type        scan_rsp;
   logic                rd_en;
   logic [PTR_W-1:0]    rd_ptr;
   logic [TIME_W-1:0]   rd_data;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WIN_W'(200);
         thr_ff    <= THR_W'(80);
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_WINDOW:    window_ff <= csr_if.data[WIN_W-1:0];
            CSR_THRESHOLD: thr_ff    <= csr_if.data[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, anything beyond the ring size as the ring size
   always_comb begin
      priority if (window_ff == '0) begin
         eff_win = CNT_W'(1);
      end else if (32'(window_ff) > WINDOW_MAX) begin
         eff_win = CNT_W'(WINDOW_MAX);
      end else begin
         eff_win = CNT_W'(window_ff);
      end
   end

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_beat     = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (req_beat) begin
         ch_ff     <= req_if.channel;
         active_ff <= req_if.attached && req_if.started && (32'(req_if.channel) < CHANNELS);
         done_ff   <= req_if.done_time;
         now_ff    <= req_if.now_time;
      end
   end

   assign idx        = ch_ff[CH_IDX_W-1:0];
   assign cur_last   = last_seen_ff[idx];
   assign cur_change = change_ff[idx];
   assign cur_head   = head_ff[idx];
   assign cur_count  = count_ff[idx];
   assign changed    = done_ff != cur_last;
   assign push_en    = (state_ff == S_LOOK) && active_ff && changed;
   assign push_ptr   = ptr_wrap((CNT_W + 1)'(cur_head) + (CNT_W + 1)'(cur_count));

   always_comb begin
      head_in  = cur_head;
      count_in = cur_count;
      // full window: drop the oldest entry instead of growing
      if ((CNT_W + 1)'(cur_count) + (CNT_W + 1)'(1) > (CNT_W + 1)'(eff_win)) begin
         head_in = ptr_wrap((CNT_W + 1)'(cur_head) + (CNT_W + 1)'(1));
      end else begin
         count_in = cur_count + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            last_seen_ff[i] <= '0;
            change_ff[i]    <= '0;
            head_ff[i]      <= '0;
            count_ff[i]     <= '0;
         end
      end else if (push_en) begin
         last_seen_ff[idx] <= done_ff;
         change_ff[idx]    <= now_ff;
         head_ff[idx]      <= head_in;
         count_ff[idx]     <= count_in;
      end
   end

   awd_ram #(
      .WIDTH (TIME_W),
      .DEPTH (HIST_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (push_en),
      .wr_addr ({idx, push_ptr}),
      .wr_data (done_ff),
      .rd_en   (rd_en),
      .rd_addr ({idx, rd_ptr}),
      .rd_data (rd_data)
   );

   assign scan_cmd.start = (state_ff == S_LOOK) && active_ff && !changed;
   assign scan_cmd.head  = cur_head;
   assign scan_cmd.count = cur_count;

   awd_gap_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .cmd     (scan_cmd),
      .rsp     (scan_rsp),
      .rd_en   (rd_en),
      .rd_ptr  (rd_ptr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (scan_cmd.start) begin
         elapsed_ff <= now_ff - cur_change;
      end
      if (state_ff == S_MUL) begin
         prod_ff     <= PROD_W'(thr_ff) * PROD_W'(scan_rsp.gap);
         gap_zero_ff <= scan_rsp.gap == '0;
      end
   end

   assign lhs      = PROD_W'({elapsed_ff, 4'b0000});
   assign load_out = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            priority if (!active_ff) begin
               status_in = ST_STOPPED;
               state_in  = S_OUT;
            end else if (changed) begin
               status_in = ST_RUNNING;
               state_in  = S_OUT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_rsp.done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            status_in = (gap_zero_ff || lhs > prod_ff) ? ST_HANGING : ST_RUNNING;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      if (load_out) begin
         rsp_ch_ff     <= ch_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.report_channel = rsp_ch_ff;
   assign rsp_if.status         = rsp_status_ff;

endmodule

`default_nettype wire

FILE: dv/tb_adaptive_hang_watchdog_unit.sv
// Self-checking testbench for adaptive_hang_watchdog_unit: drives polls and register
// writes, predicts every report and compares it field by field as it leaves the block.
// Depends on awd_pkg and the awd_req_if / awd_rsp_if / awd_csr_if interfaces.
module tb_adaptive_hang_watchdog_unit;
   import awd_pkg::*;

   typedef struct packed {
      logic [CH_W-1:0]     channel;
      logic [STATUS_W-1:0] status;
   } report_type;

   logic clock;
   logic reset;

   awd_req_if req_bus ();
   awd_rsp_if rsp_bus ();
   awd_csr_if csr_bus ();

   adaptive_hang_watchdog_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // Predicted block state, updated only by the monitor at accepted beats
   logic [WIN_W-1:0]  watch_window;
   logic [THR_W-1:0]  watch_threshold;
   logic [TIME_W-1:0] seen_done   [CHANNELS];
   logic [TIME_W-1:0] changed_at  [CHANNELS];
   logic [TIME_W-1:0] done_ring   [CHANNELS][WINDOW_MAX];
   logic [PTR_W-1:0]  ring_head   [CHANNELS];
   logic [CNT_W-1:0]  ring_fill   [CHANNELS];

   report_type pending_reports [$];
   int      errors;
   int      polls_sent;
   int      reports_seen;
   int      hold_left;
   int      cfg_threshold;
   bit      calm;

   // Sender-side view of each channel, used only to aim the stimulus
   logic [TIME_W-1:0] trk_done   [CHANNELS];
   logic [TIME_W-1:0] trk_change [CHANNELS];
   logic [TIME_W-1:0] trk_gap    [CHANNELS];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("tb_adaptive_hang_watchdog_unit: done, errors");
      $finish;
   end

   function automatic logic [TIME_W-1:0] largest_rise(input int ch);
      logic [TIME_W-1:0] gap;
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
      gap = '0;
      for (int k = 1; k < ring_fill[ch]; k++) begin
         a = done_ring[ch][PTR_W'(ring_head[ch] + k - 1)];
         b = done_ring[ch][PTR_W'(ring_head[ch] + k)];
         if (b > a && b - a > gap) begin
            gap = b - a;
         end
      end
      return gap;
   endfunction

   function automatic logic [STATUS_W-1:0] judge_poll(input int ch, input logic att, sta,
                                                      input logic [TIME_W-1:0] done, now);
      logic [CNT_W-1:0]  win;
      logic [PTR_W-1:0]  slot;
      logic [TIME_W-1:0] gap;
      logic [TIME_W-1:0] elapsed;
      if (!(att && sta)) begin
         return ST_STOPPED;
      end
      if (done != seen_done[ch]) begin
         if (watch_window == '0) begin
            win = CNT_W'(1);
         end else if (watch_window > WINDOW_MAX) begin
            win = CNT_W'(WINDOW_MAX);
         end else begin
            win = CNT_W'(watch_window);
         end
         slot = PTR_W'(ring_head[ch] + ring_fill[ch]);
         done_ring[ch][slot] = done;
         // a full ring drops its oldest entry; a shrunk window drops one per append
         if (ring_fill[ch] + 1 > win) begin
            ring_head[ch] = ring_head[ch] + 1'b1;
         end else begin
            ring_fill[ch] = ring_fill[ch] + 1'b1;
         end
         seen_done[ch]  = done;
         changed_at[ch] = now;
         return ST_RUNNING;
      end
      gap     = largest_rise(ch);
      elapsed = now - changed_at[ch];
      if (gap == '0 || 64'(elapsed) * 64'd16 > 64'(watch_threshold) * 64'(gap)) begin
         return ST_HANGING;
      end
      return ST_RUNNING;
   endfunction

   always @(posedge clock) begin : monitor
      report_type want;
      if (reset) begin
         watch_window    = WIN_W'(200);
         watch_threshold = THR_W'(80);
         for (int c = 0; c < CHANNELS; c++) begin
            seen_done[c]  = '0;
            changed_at[c] = '0;
            ring_head[c]  = '0;
            ring_fill[c]  = '0;
         end
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_WINDOW:    watch_window = csr_bus.data[WIN_W-1:0];
               CSR_THRESHOLD: watch_threshold = csr_bus.data[THR_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            want.channel = req_bus.channel;
            want.status  = judge_poll(req_bus.channel, req_bus.attached, req_bus.started,
                                      req_bus.done_time, req_bus.now_time);
            pending_reports.insert(pending_reports.size(), want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_reports.size() == 0) begin
               errors++;
               $display("%0t: report with nothing pending: channel %0d status %0d", $time,
                        rsp_bus.report_channel, rsp_bus.status);
            end else begin
               want = pending_reports[0];
               pending_reports.delete(0);
               reports_seen++;
               if (rsp_bus.report_channel !== want.channel) begin
                  errors++;
                  $display("%0t: report_channel expected %0d actual %0d", $time,
                           want.channel, rsp_bus.report_channel);
               end
               if (rsp_bus.status !== want.status) begin
                  errors++;
                  $display("%0t: status on channel %0d expected %0d actual %0d", $time,
                           want.channel, want.status, rsp_bus.status);
               end
            end
         end
      end
   end

   // Result sink: random stalls, a calm stretch, and a counted hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(99) >= 21);
      end
   end

   task automatic send_poll(input logic [CH_W-1:0] ch, input logic att, sta,
                            input logic [TIME_W-1:0] done, now);
      while (!calm && $urandom_range(99) < 21) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.channel   <= ch;
      req_bus.attached  <= att;
      req_bus.started   <= sta;
      req_bus.done_time <= done;
      req_bus.now_time  <= now;
      do @(posedge clock); while (!req_bus.ready);
      polls_sent++;
      if (att && sta && done != trk_done[ch]) begin
         trk_done[ch]   = done;
         trk_change[ch] = now;
      end
   endtask

   // Drop valid and hold until every pending report has come back
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (reports_seen != polls_sent);
   endtask

   task automatic write_config(input logic [CSR_DATA_W-1:0] win, thr);
      wait_idle();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_WINDOW;
      csr_bus.data  <= win;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.index <= CSR_THRESHOLD;
      csr_bus.data  <= thr;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      cfg_threshold = thr;
   endtask

   task automatic send_random_poll();
      logic [CH_W-1:0]   ch;
      logic [TIME_W-1:0] step;
      logic [TIME_W-1:0] elapsed;
      logic [1:0]        flags;
      int                pick;
      ch   = CH_W'($urandom_range(CHANNELS - 1));
      pick = $urandom_range(99);
      if (pick < 45) begin
         step = $urandom_range(1, 64);
         if (step > trk_gap[ch]) begin
            trk_gap[ch] = step;
         end
         send_poll(ch, 1'b1, 1'b1, trk_done[ch] + step,
                   trk_done[ch] + step + $urandom_range(0, 3));
      end else if (pick < 80) begin
         // aim near the timeout edge so both outcomes show up
         elapsed = (cfg_threshold * trk_gap[ch]) / 16 + $urandom_range(0, 6);
         elapsed = (elapsed >= 3) ? elapsed - 3 : '0;
         if ($urandom_range(9) == 0) begin
            elapsed = $urandom;
         end
         send_poll(ch, 1'b1, 1'b1, trk_done[ch], trk_change[ch] + elapsed);
      end else if (pick < 90) begin
         flags = 2'($urandom_range(0, 2));
         send_poll(ch, flags[1], flags[0], $urandom, $urandom);
      end else begin
         send_poll(ch, 1'b1, 1'b1, $urandom, $urandom);
      end
   endtask

   task automatic test_stopped_polls();
      send_poll(3'd7, 1'b0, 1'b1, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
      send_poll(3'd7, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_poll(3'd7, 1'b0, 1'b0, 32'h0000_0001, 32'h0000_0000);
      // state untouched: still the reset completion time, no history
      send_poll(3'd7, 1'b1, 1'b1, 32'h0, 32'd10);
   endtask

   task automatic test_short_history();
      send_poll(3'd0, 1'b1, 1'b1, 32'd0, 32'd0);
      send_poll(3'd0, 1'b1, 1'b1, 32'd100, 32'd110);
      send_poll(3'd0, 1'b1, 1'b1, 32'd100, 32'd115);
   endtask

   task automatic test_threshold_edges();
      send_poll(3'd1, 1'b1, 1'b1, 32'd1000, 32'd1000);
      send_poll(3'd1, 1'b1, 1'b1, 32'd1200, 32'd1200);
      send_poll(3'd1, 1'b1, 1'b1, 32'd1200, 32'd1200);
      send_poll(3'd1, 1'b1, 1'b1, 32'd1200, 32'd2200);
      send_poll(3'd1, 1'b1, 1'b1, 32'd1200, 32'd2201);
      write_config(12'd200, 12'd0);
      send_poll(3'd1, 1'b1, 1'b1, 32'd1200, 32'd1200);
      send_poll(3'd1, 1'b1, 1'b1, 32'd1200, 32'd1201);
      write_config(12'd200, 12'd4095);
      send_poll(3'd1, 1'b1, 1'b1, 32'd1200, 32'd1200 + 32'd51187);
      send_poll(3'd1, 1'b1, 1'b1, 32'd1200, 32'd1200 + 32'd51188);
      send_poll(3'd1, 1'b1, 1'b1, 32'd1200, 32'd1199);
      write_config(12'd200, 12'd80);
   endtask

   task automatic test_falling_times();
      send_poll(3'd2, 1'b1, 1'b1, 32'd500, 32'd500);
      send_poll(3'd2, 1'b1, 1'b1, 32'd400, 32'd600);
      send_poll(3'd2, 1'b1, 1'b1, 32'd450, 32'd700);
      send_poll(3'd2, 1'b1, 1'b1, 32'd450, 32'd950);
      send_poll(3'd2, 1'b1, 1'b1, 32'd450, 32'd951);
   endtask

   task automatic test_time_wrap();
      send_poll(3'd3, 1'b1, 1'b1, 32'hFFFF_FF00, 32'hFFFF_FFF0);
      send_poll(3'd3, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_poll(3'd3, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0000_0010);
      send_poll(3'd3, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_poll(3'd3, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000);
   endtask

   task automatic test_window_limits();
      logic [TIME_W-1:0] step;
      write_config(12'd0, 12'd80);
      send_poll(3'd4, 1'b1, 1'b1, 32'd10, 32'd10);
      send_poll(3'd4, 1'b1, 1'b1, 32'd30, 32'd30);
      send_poll(3'd4, 1'b1, 1'b1, 32'd60, 32'd60);
      send_poll(3'd4, 1'b1, 1'b1, 32'd60, 32'd61);
      // above the ring size: fill past the end so the oldest entries roll off
      write_config(12'h1FF, 12'd80);
      for (int i = 0; i < 260; i++) begin
         step = $urandom_range(1, 100);
         send_poll(3'd5, 1'b1, 1'b1, trk_done[5] + step, trk_done[5] + step);
      end
      send_poll(3'd5, 1'b1, 1'b1, trk_done[5], trk_change[5] + 32'd400);
      send_poll(3'd5, 1'b1, 1'b1, trk_done[5], trk_change[5] + 32'd10000);
      write_config(12'd256, 12'd80);
      send_poll(3'd5, 1'b1, 1'b1, trk_done[5] + 32'd7, trk_done[5] + 32'd7);
      // shrink: the count stays, only the head moves
      write_config(12'd2, 12'd80);
      send_poll(3'd5, 1'b1, 1'b1, trk_done[5] + 32'd3, trk_done[5] + 32'd3);
      send_poll(3'd5, 1'b1, 1'b1, trk_done[5] + 32'd9, trk_done[5] + 32'd9);
      send_poll(3'd5, 1'b1, 1'b1, trk_done[5], trk_change[5] + 32'd500);
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_left = 400;
      for (int i = 0; i < 10; i++) begin
         send_random_poll();
      end
      wait_idle();
   endtask

   task automatic test_random_polls(input logic [CSR_DATA_W-1:0] win, thr,
                                    input int items, input bit calm_run);
      write_config(win, thr);
      for (int c = 0; c < CHANNELS; c++) begin
         trk_gap[c] = '0;
      end
      calm = calm_run;
      for (int i = 0; i < items; i++) begin
         send_random_poll();
         if ($urandom_range(199) == 0) begin
            wait_idle();
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      errors        = 0;
      polls_sent    = 0;
      reports_seen  = 0;
      hold_left     = 0;
      cfg_threshold = 80;
      calm          = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         trk_done[c]   = '0;
         trk_change[c] = '0;
         trk_gap[c]    = '0;
      end
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.channel   <= '0;
      req_bus.attached  <= 1'b0;
      req_bus.started   <= 1'b0;
      req_bus.done_time <= '0;
      req_bus.now_time  <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= CSR_WINDOW;
      csr_bus.data      <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_stopped_polls();
      test_short_history();
      test_threshold_edges();
      test_falling_times();
      test_time_wrap();
      test_window_limits();
      test_backpressure();
      test_random_polls(12'd4, 12'd80, 400, 1'b0);
      test_random_polls(12'd1, 12'd0, 300, 1'b0);
      test_random_polls(12'd16, 12'd4095, 400, 1'b0);
      test_random_polls(12'hE03, 12'd24, 400, 1'b1);
      test_random_polls(12'd0, 12'd120, 200, 1'b0);
      test_random_polls(12'd200, 12'd80, 300, 1'b0);

      wait_idle();
      repeat (300) @(posedge clock);
      if (pending_reports.size() != 0) begin
         errors++;
         $display("%0t: %0d reports never arrived", $time, pending_reports.size());
      end
      if (errors == 0) begin
         $display("tb_adaptive_hang_watchdog_unit: done, clean");
      end else begin
         $display("tb_adaptive_hang_watchdog_unit: done, errors");
      end
      $finish;
   end

endmodule
